// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field widths, request codes, beat payload types and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_FIELD_W  = 16;
  localparam int KEY_FIELD_W = 16;
  localparam int OCC_W       = 7;

  // Request codes carried in req_type.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_ERASE  = 1'b1;

  // Read address selection relative to the datapath pointer.
  localparam logic [1:0] RD_PREV = 2'd0;
  localparam logic [1:0] RD_CUR  = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  typedef struct packed {
    logic                   req_type;
    logic [ID_FIELD_W-1:0]  item_id;
    logic [KEY_FIELD_W-1:0] item_key;
  } req_t;

  typedef struct packed {
    logic                  done_ok;
    logic                  was_full;
    logic                  head_valid;
    logic [ID_FIELD_W-1:0] head_id;
    logic [OCC_W-1:0]      occupancy;
  } rsp_t;

  typedef struct packed {
    logic       load_req;
    logic       ptr_load_count;
    logic       ptr_clear;
    logic       ptr_inc;
    logic       ptr_dec;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic       wr_new;
    logic       count_inc;
    logic       count_dec;
    logic       rsp_load;
    logic       rsp_ok;
    logic       rsp_full;
  } spq_cmd_t;

  typedef struct packed {
    logic op_erase;
    logic full;
    logic ptr_zero;
    logic ptr_end;
    logic next_end;
    logic key_ge;
    logic key_gt_id;
    logic id_match;
    logic out_free;
  } spq_status_t;

endpackage

// ===== src/spq_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface spq_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== src/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Holds up to CAPACITY (id, key) entries in ascending key order in one RAM
// and answers every insert or erase request with one status beat.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake       Beat contents
//   -------   ---   -------------   ------------------------------------------
//   req       in    valid / ready   req_type, item_id, item_key
//   rsp       out   valid / ready   done_ok, was_full, head_valid, head_id,
//                                   occupancy
//
// One request is worked at a time. An insert walks down from the tail,
// moving each entry whose key is not below the new key up by one slot with
// a read state and a write state per slot, set by the single read port of
// the entry RAM and its registered read. An erase searches from the head,
// a read and a compare state per entry, and then closes the gap with a read
// and a write state per entry.
// Reset clears the entry count and the result valid; the RAM is never
// cleared, since only slots below the count are read. A stalled result beat
// holds in the output register and the block takes no new request until that
// result has been loaded.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int ID_WIDTH  = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  spq_stream_if.sink   req,
  spq_stream_if.source rsp
);

  // Only the low field bits are ever significant, so storage is never wider
  // than the beat fields.
  localparam int IW = (ID_WIDTH  < ID_FIELD_W)  ? ID_WIDTH  : ID_FIELD_W;
  localparam int KW = (KEY_WIDTH < KEY_FIELD_W) ? KEY_WIDTH : KEY_FIELD_W;

  spq_cmd_t    cmd;
  spq_status_t status;

  // The controller owns the request handshake and the walk sequence.
  spq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .status  (status),
    .cmd     (cmd)
  );

  // The datapath owns the entry RAM, the count and the result register.
  spq_datapath #(
    .CAPACITY(CAPACITY),
    .IW      (IW),
    .KW      (KW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req.data),
    .cmd      (cmd),
    .status   (status),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .rsp_data (rsp.data)
  );

endmodule

// ===== src/spq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences the shift-up walk of an insert and the search and shift-down walk
// of an erase, then hands the outcome to the result register.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  spq_status_t status,
  output spq_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISPATCH = 4'd1;
  localparam logic [3:0] ST_INS_CHK  = 4'd2;
  localparam logic [3:0] ST_INS_CMP  = 4'd3;
  localparam logic [3:0] ST_ERS_CHK  = 4'd4;
  localparam logic [3:0] ST_ERS_CMP  = 4'd5;
  localparam logic [3:0] ST_SHF_CHK  = 4'd6;
  localparam logic [3:0] ST_SHF_WR   = 4'd7;
  localparam logic [3:0] ST_RESULT   = 4'd8;

  logic [3:0] state, state_next;
  logic       res_ok, res_ok_next;
  logic       res_full, res_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_ok   <= 1'b0;
      res_full <= 1'b0;
    end else begin
      state    <= state_next;
      res_ok   <= res_ok_next;
      res_full <= res_full_next;
    end
  end

  always_comb begin
    state_next    = state;
    res_ok_next   = res_ok;
    res_full_next = res_full;
    cmd           = '0;
    cmd.rd_sel    = RD_CUR;
    in_ready      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req  = 1'b1;
          res_ok_next   = 1'b0;
          res_full_next = 1'b0;
          state_next    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.op_erase == REQ_ERASE) begin
          cmd.ptr_clear = 1'b1;
          state_next    = ST_ERS_CHK;
        end else if (status.full) begin
          res_full_next = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          cmd.ptr_load_count = 1'b1;
          state_next         = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (status.ptr_zero) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          res_ok_next   = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (status.key_ge) begin
          cmd.ptr_dec = 1'b1;
          state_next  = ST_INS_CHK;
        end else begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          res_ok_next   = 1'b1;
          state_next    = ST_RESULT;
        end
      end
      ST_ERS_CHK: begin
        if (status.ptr_end) begin
          state_next = ST_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = ST_ERS_CMP;
        end
      end
      ST_ERS_CMP: begin
        if (status.key_gt_id) begin
          state_next = ST_RESULT;
        end else if (status.id_match) begin
          res_ok_next = 1'b1;
          state_next  = ST_SHF_CHK;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = ST_ERS_CHK;
        end
      end
      ST_SHF_CHK: begin
        if (status.next_end) begin
          cmd.count_dec = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = ST_SHF_WR;
        end
      end
      ST_SHF_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.ptr_inc = 1'b1;
        state_next  = ST_SHF_CHK;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_ok   = res_ok;
          cmd.rsp_full = res_full;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry memory, walk pointer, entry count, head id copy, comparators and the
// result register.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int IW       = 16,
  parameter int KW       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req_data,
  input  spq_cmd_t    cmd,
  output spq_status_t status,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int DW = KW + IW;

  logic          req_op;
  logic [IW-1:0] req_id;
  logic [KW-1:0] req_key;
  logic [PW-1:0] ptr;
  logic [PW-1:0] count;
  logic [IW-1:0] head;

  logic [PW-1:0] ptr_prev, ptr_next, rd_ptr;
  logic [DW-1:0] wr_data, rd_data;
  logic [KW-1:0] rd_key;
  logic [IW-1:0] rd_id;
  logic          count_nz;

  assign ptr_prev = ptr - PW'(1);
  assign ptr_next = ptr + PW'(1);
  assign rd_key   = rd_data[DW-1:IW];
  assign rd_id    = rd_data[IW-1:0];
  assign wr_data  = cmd.wr_new ? {req_key, req_id} : rd_data;
  assign count_nz = (count != '0);

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_ptr = ptr_prev;
      RD_NEXT: rd_ptr = ptr_next;
      default: rd_ptr = ptr;
    endcase
  end

  spq_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(ptr[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_ptr[AW-1:0]),
    .rd_data(rd_data)
  );

  // Request capture, walk pointer and head copy.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op  <= req_data.req_type;
      req_id  <= req_data.item_id[IW-1:0];
      req_key <= req_data.item_key[KW-1:0];
    end
    if (cmd.ptr_clear) begin
      ptr <= '0;
    end else if (cmd.ptr_load_count) begin
      ptr <= count;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_next;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_prev;
    end
    if (cmd.wr_en && (ptr == '0)) begin
      head <= wr_data[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + PW'(1);
      end else if (cmd.count_dec) begin
        count <= count - PW'(1);
      end
      if (cmd.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp_data.done_ok    <= cmd.rsp_ok;
      rsp_data.was_full   <= cmd.rsp_full;
      rsp_data.head_valid <= count_nz;
      rsp_data.head_id    <= count_nz ? ID_FIELD_W'(head) : '0;
      rsp_data.occupancy  <= OCC_W'(count);
    end
  end

  always_comb begin
    status.op_erase  = req_op;
    status.full      = (count == PW'(CAPACITY));
    status.ptr_zero  = (ptr == '0);
    status.ptr_end   = (ptr == count);
    status.next_end  = (ptr_next >= count);
    status.key_ge    = (rd_key >= req_key);
    status.key_gt_id = (KEY_FIELD_W'(rd_key) > KEY_FIELD_W'(req_id));
    status.id_match  = (rd_id == req_id);
    status.out_free  = !rsp_valid || rsp_ready;
  end

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is still in work");

  a_full_not_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.was_full && rsp_data.done_ok))
    else $error("rejected insert reported as done");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.was_full) |-> (rsp_data.occupancy == OCC_W'(CAPACITY)))
    else $error("full rejection with store not at capacity");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.head_valid) |->
      ((rsp_data.head_id == '0) && (rsp_data.occupancy == '0)))
    else $error("empty store reports a head or a count");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled result beat changed");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .CAPACITY(CAPACITY)
) u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data (rsp.data)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives insert and erase requests into the core, keeps a shadow copy of the
// sorted store, and checks every status beat field by field against it. A
// directed opening covers the corner cases. Three random phases follow, each
// with its own idle pattern, and they fill the store to capacity and drain it
// again.
// ----------------------------------------------------------------------------

// One held entry of the shadow store.
typedef struct packed {
  logic [spq_pkg::ID_FIELD_W-1:0]  id;
  logic [spq_pkg::KEY_FIELD_W-1:0] key;
} slot_t;

// Shadow of the sorted store plus the status beats still due from the core.
class queue_shadow;
  slot_t         held[$];
  spq_pkg::rsp_t statuses_due[$];
  int            depth;
  int            errors;
  int            checked;
  int            inserts_ok;
  int            full_rejects;
  int            erase_hits;
  int            erase_misses;
  int            peak_fill;
  int            print_limit = 30;

  function new(int capacity);
    depth        = capacity;
    errors       = 0;
    checked      = 0;
    inserts_ok   = 0;
    full_rejects = 0;
    erase_hits   = 0;
    erase_misses = 0;
    peak_fill    = 0;
  endfunction

  // Applies one accepted request to the shadow store and queues its status.
  function void apply_request(spq_pkg::req_t r);
    spq_pkg::rsp_t st;
    slot_t         s;
    int            pos;
    st = '0;
    if (r.req_type == spq_pkg::REQ_INSERT) begin
      if (held.size() >= depth) begin
        st.was_full = 1'b1;
        full_rejects++;
      end else begin
        // Land in front of the first entry whose key is not below the new one.
        pos = 0;
        while (pos < held.size() && held[pos].key < r.item_key) pos++;
        s.id  = r.item_id;
        s.key = r.item_key;
        held.insert(pos, s);
        st.done_ok = 1'b1;
        inserts_ok++;
      end
    end else begin
      // The requested id is compared against the keys to cut the walk short.
      for (pos = 0; pos < held.size(); pos++) begin
        if (held[pos].key > r.item_id) break;
        if (held[pos].id == r.item_id) begin
          held.delete(pos);
          st.done_ok = 1'b1;
          break;
        end
      end
      if (st.done_ok) erase_hits++;
      else erase_misses++;
    end
    st.head_valid = (held.size() != 0);
    st.head_id    = (held.size() != 0) ? held[0].id : '0;
    st.occupancy  = 7'(held.size());
    if (held.size() > peak_fill) peak_fill = held.size();
    statuses_due.push_back(st);
  endfunction

  task report_mismatch(string what);
    errors++;
    if (errors <= print_limit) $display("MISMATCH at status beat %0d: %s", checked, what);
  endtask

  // Compares one status beat with the oldest outstanding expectation.
  task check_status(spq_pkg::rsp_t got);
    spq_pkg::rsp_t want;
    if (statuses_due.size() == 0) begin
      report_mismatch($sformatf("beat with no request outstanding (head_id 0x%0h)",
                                got.head_id));
    end else begin
      want = statuses_due.pop_front();
      checked++;
      if (got.done_ok !== want.done_ok)
        report_mismatch($sformatf("done_ok %0b, expected %0b", got.done_ok, want.done_ok));
      if (got.was_full !== want.was_full)
        report_mismatch($sformatf("was_full %0b, expected %0b", got.was_full, want.was_full));
      if (got.head_valid !== want.head_valid)
        report_mismatch($sformatf("head_valid %0b, expected %0b", got.head_valid,
                                  want.head_valid));
      if (got.head_id !== want.head_id)
        report_mismatch($sformatf("head_id 0x%0h, expected 0x%0h", got.head_id, want.head_id));
      if (got.occupancy !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", got.occupancy,
                                  want.occupancy));
    end
  endtask
endclass

module tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH    = 64;
  localparam int PHASE_ITEMS    = 250;
  // A drain run gives up after this many requests, since entries whose key
  // exceeds their own id can never be erased and may keep the store nonempty.
  localparam int DRAIN_SPAN     = 96;
  // The core walks its held entries one by one, so the settle span grows with the depth.
  localparam int SETTLE_CYCLES  = 2 * QUEUE_DEPTH + 24;
  localparam int HOLD_CYCLES    = 600;
  // Longest correct quiet spell: the long receiver hold plus one slow request
  // and a run of random stalls; the limit leaves a wide margin over that.
  localparam int WATCHDOG_LIMIT = 6000;

  typedef enum logic {TREND_FILL, TREND_DRAIN} trend_e;

  logic clk;
  logic rst;

  spq_stream_if #(.payload_t(req_t)) req_ch ();
  spq_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  sorted_priority_queue_core #(
    .CAPACITY  (QUEUE_DEPTH),
    .ID_WIDTH  (ID_FIELD_W),
    .KEY_WIDTH (KEY_FIELD_W)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  queue_shadow shadow;

  // Idle odds in percent for each side, and a request for a long receiver
  // hold that the receiver process picks up and counts down on its own.
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_request;
  trend_e trend;
  int     drain_steps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: checks every status beat taken at an edge, then picks ready for
  // the next cycle. Only one assignment to ready happens per edge.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) shadow.check_status(rsp_ch.data);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no beat for %0d cycles, %0d status beats still due",
             WATCHDOG_LIMIT, shadow.statuses_due.size());
    $display("TEST FAILED");
    $finish;
  end

  // Offers one request and returns at the edge where it is accepted. Valid is
  // left high so that a back-to-back request keeps it up without a glitch; it
  // only drops when the next call decides to idle or the sender waits for results.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    shadow.apply_request(r);
  endtask

  // Stops offering and waits until every status beat has come back. The
  // extra edge keeps the drop of valid apart from the next raise.
  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    while (shadow.statuses_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Builds the next random request. Most traffic follows the current trend:
  // a fill run is mostly inserts with key not above id, so each entry stays
  // erasable; a drain run is mostly erases of ids actually held. A small
  // share of fully random requests adds noise and unerasable entries.
  function automatic req_t next_request();
    req_t  r;
    slot_t pick;
    int    roll;
    bit    do_insert;
    roll       = $urandom_range(99);
    r.item_key = KEY_FIELD_W'($urandom_range(65535));
    r.item_id  = ID_FIELD_W'($urandom_range(65535));
    if (roll < 5) begin
      r.req_type = $urandom_range(1) ? REQ_ERASE : REQ_INSERT;
    end else begin
      do_insert = (trend == TREND_FILL) ? (roll < 88) : (roll >= 88);
      if (do_insert) begin
        r.req_type = REQ_INSERT;
        if (shadow.held.size() != 0 && $urandom_range(99) < 20) begin
          // Reuse a held key so that equal keys stack up.
          pick       = shadow.held[$urandom_range(shadow.held.size() - 1)];
          r.item_key = pick.key;
          r.item_id  = ID_FIELD_W'($urandom_range(65535, pick.key));
        end else begin
          r.item_key = KEY_FIELD_W'($urandom_range(r.item_id, 0));
        end
      end else begin
        r.req_type = REQ_ERASE;
        if (shadow.held.size() != 0 && $urandom_range(99) < 80) begin
          pick      = shadow.held[$urandom_range(shadow.held.size() - 1)];
          r.item_id = pick.id;
        end
      end
    end
    return r;
  endfunction

  // Turns a fill run into a drain once the store has been full for a few
  // rejected inserts, and back again once it is empty or the run is long.
  task automatic steer_trend();
    if (trend == TREND_FILL) begin
      if (shadow.held.size() >= QUEUE_DEPTH && $urandom_range(3) == 0) begin
        trend       = TREND_DRAIN;
        drain_steps = 0;
      end
    end else begin
      drain_steps++;
      if (shadow.held.size() == 0 || drain_steps >= DRAIN_SPAN) trend = TREND_FILL;
    end
  endtask

  initial begin
    shadow        = new(QUEUE_DEPTH);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 0;
    trend         = TREND_FILL;
    drain_steps   = 0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    rst          <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening, with both sides running flat out.
    // Erase on an empty store.
    send_request(req_t'{REQ_ERASE,  16'h0000, 16'h0000});
    // Key and id extremes.
    send_request(req_t'{REQ_INSERT, 16'hFFFF, 16'hFFFF});
    send_request(req_t'{REQ_INSERT, 16'h0000, 16'h0000});
    // Equal key: the newcomer goes in front, so it becomes the head.
    send_request(req_t'{REQ_INSERT, 16'h1234, 16'h0000});
    send_request(req_t'{REQ_INSERT, 16'h9000, 16'h8000});
    // The walk passes both zero keys and stops early at key 0x8000, which is
    // above the requested id 0x00FF.
    send_request(req_t'{REQ_ERASE,  16'h00FF, 16'h0000});
    // Hit in the middle; the key field is ignored on an erase.
    send_request(req_t'{REQ_ERASE,  16'h9000, 16'hFFFF});
    // Hit at the head, then at the new head.
    send_request(req_t'{REQ_ERASE,  16'h1234, 16'h0000});
    send_request(req_t'{REQ_ERASE,  16'h0000, 16'h0000});
    // Same id again: the remaining key 0xFFFF stops the walk at once.
    send_request(req_t'{REQ_ERASE,  16'h0000, 16'h5A5A});
    // Remove the last entry, then erase on the empty store once more.
    send_request(req_t'{REQ_ERASE,  16'hFFFF, 16'h0000});
    send_request(req_t'{REQ_ERASE,  16'hFFFF, 16'hFFFF});
    // Alternating bit patterns in both fields, with another equal-key insert.
    send_request(req_t'{REQ_INSERT, 16'hAAAA, 16'h5555});
    send_request(req_t'{REQ_INSERT, 16'h5555, 16'h5555});
    send_request(req_t'{REQ_INSERT, 16'h7FFF, 16'h0001});
    send_request(req_t'{REQ_ERASE,  16'h5555, 16'h0000});
    send_request(req_t'{REQ_ERASE,  16'hAAAA, 16'h0000});
    send_request(req_t'{REQ_ERASE,  16'h7FFF, 16'h0000});
    wait_all_results();

    // Random phases: sender mostly busy with a lazy receiver, then the
    // reverse, then no idling at all. The first phase also holds the
    // receiver off for a long stretch so that the core backs up and stalls
    // its request side while the sender keeps offering.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 28 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 120) hold_request = HOLD_CYCLES;
        send_request(next_request());
        steer_trend();
      end
      // The sender pauses here until every status beat is back.
      wait_all_results();
    end

    // Give the core time to show any stray beat before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d status beats: %0d inserts placed, %0d rejected on a full store,",
             shadow.checked, shadow.inserts_ok, shadow.full_rejects);
    $display("%0d erases hit, %0d missed; fill peaked at %0d of %0d entries.",
             shadow.erase_hits, shadow.erase_misses, shadow.peak_fill, QUEUE_DEPTH);
    if (shadow.errors == 0 && shadow.statuses_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
